### rtl/mstb_pkg.sv
// ---------------------------------------------------------------------------
// mstb_pkg: shared types and constants of the timer slot bank
// Slot record, request codes, controller states and result field widths.
// ---------------------------------------------------------------------------
package mstb_pkg;

    localparam int CNT_W  = 16;
    localparam int SLOT_W = 3;
    localparam int RPT_W  = 4;
    localparam logic [RPT_W-1:0] MAX_REPORTS = 4'd8;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_CREATE = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_POLL   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SWEEP = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] rem;
        logic [CNT_W-1:0] reload;
        logic             periodic;
        logic             notify;
    } slot_t;

endpackage

### rtl/mstb_cell.sv
// ---------------------------------------------------------------------------
// mstb_cell: one timer slot of the ring
// Holds one slot record and takes its neighbor's record on each shift.
// ---------------------------------------------------------------------------
module mstb_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  mstb_pkg::slot_t d,
    output mstb_pkg::slot_t q
);

    logic                       en_reg;
    logic [mstb_pkg::CNT_W-1:0] rem_reg;
    logic [mstb_pkg::CNT_W-1:0] reload_reg;
    logic                       periodic_reg;
    logic                       notify_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else if (shift)
        begin
            en_reg <= d.en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rem_reg      <= d.rem;
            reload_reg   <= d.reload;
            periodic_reg <= d.periodic;
            notify_reg   <= d.notify;
        end
    end

    assign q.en       = en_reg;
    assign q.rem      = rem_reg;
    assign q.reload   = reload_reg;
    assign q.periodic = periodic_reg;
    assign q.notify   = notify_reg;

endmodule

### rtl/multi_slot_timer_bank.sv
// ---------------------------------------------------------------------------
// multi_slot_timer_bank: bank of one-shot and periodic timer slots
// Tick, create, delete and poll requests served by a rotating ring of slots.
// ---------------------------------------------------------------------------
// The slots sit in a ring of cells that rotates by one slot per cycle past a
// single update point, so every request walks the whole ring. The ring holds
// while a poll report waits on an untaken result register. A request is
// accepted, swept past every slot, then gives its final result. Requests
// are taken one at a time. Tick, create and delete give one result; a poll
// gives one result per expired slot (at most eight), in slot order, or one
// empty result, with tlast on the final one.
module multi_slot_timer_bank
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // period[15:0], periodic[16], notify[17], slot[20:18]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status[0], slot_out[3:1], fired[4]
    output logic        m_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W = (IDX_W > mstb_pkg::SLOT_W) ? IDX_W : mstb_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    mstb_pkg::state_t state_reg, state_next;

    mstb_pkg::func_t                func_reg;
    logic [mstb_pkg::CNT_W-1:0]     period_reg;
    logic                           periodic_reg;
    logic                           notify_reg;
    logic [mstb_pkg::SLOT_W-1:0]    sel_reg;

    logic [IDX_W-1:0]               cnt_reg;
    logic                           found_reg;
    logic [mstb_pkg::SLOT_W-1:0]    found_slot_reg;
    logic                           del_ok_reg;
    logic                           pend_valid_reg;
    logic [mstb_pkg::SLOT_W-1:0]    pend_slot_reg;
    logic [mstb_pkg::RPT_W-1:0]     n_reg;

    logic                           out_valid_reg;
    logic                           out_status_reg;
    logic [mstb_pkg::SLOT_W-1:0]    out_slot_reg;
    logic                           out_fired_reg;
    logic                           out_last_reg;

    mstb_pkg::slot_t                cell_q [NUM_SLOTS];
    mstb_pkg::slot_t                head;
    mstb_pkg::slot_t                head_new;

    logic                           accept;
    logic                           sweeping;
    logic                           advance;
    logic                           out_free;
    logic                           fires;
    logic                           report;
    logic                           push_sweep;
    logic                           push_flush;
    logic                           do_create;
    logic                           do_delete;
    logic [mstb_pkg::SLOT_W-1:0]    cnt_slot;
    logic                           fin_status;
    logic [mstb_pkg::SLOT_W-1:0]    fin_slot;
    logic                           fin_fired;

    // slot ring
    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            mstb_pkg::slot_t cell_d;
            if (gi == NUM_SLOTS - 1)
            begin : g_tail
                assign cell_d = head_new;
            end
            else
            begin : g_link
                assign cell_d = cell_q[gi + 1];
            end
            mstb_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (advance),
                .d     (cell_d),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    assign head     = cell_q[0];
    assign cnt_slot = mstb_pkg::SLOT_W'(cnt_reg);
    assign accept   = s_tvalid && s_tready;
    assign sweeping = (state_reg == mstb_pkg::ST_SWEEP);
    assign out_free = !out_valid_reg || m_tready;

    assign fires     = (func_reg == mstb_pkg::FUNC_POLL) && head.en && head.notify
                       && (head.rem == '0);
    assign report    = fires && (n_reg < mstb_pkg::MAX_REPORTS);
    assign advance   = sweeping && !(report && pend_valid_reg && !out_free);
    assign push_sweep = advance && report && pend_valid_reg;
    assign push_flush = (state_reg == mstb_pkg::ST_FLUSH) && out_free;
    assign do_create = (func_reg == mstb_pkg::FUNC_CREATE) && !found_reg && !head.en;
    assign do_delete = (func_reg == mstb_pkg::FUNC_DELETE) && head.en
                       && (CMP_W'(cnt_reg) == CMP_W'(sel_reg));

    // update the slot at the head of the ring
    always_comb
    begin
        head_new = head;
        case (func_reg)
            mstb_pkg::FUNC_TICK:
            begin
                if (head.en && (head.rem != '0))
                begin
                    head_new.rem = head.rem - 1'b1;
                end
            end
            mstb_pkg::FUNC_CREATE:
            begin
                if (do_create)
                begin
                    head_new.en       = 1'b1;
                    head_new.rem      = period_reg;
                    head_new.reload   = period_reg;
                    head_new.periodic = periodic_reg;
                    head_new.notify   = notify_reg;
                end
            end
            mstb_pkg::FUNC_DELETE:
            begin
                if (do_delete)
                begin
                    head_new.en = 1'b0;
                end
            end
            mstb_pkg::FUNC_POLL:
            begin
                if (fires)
                begin
                    if (head.periodic)
                    begin
                        head_new.rem = head.reload;
                    end
                    else
                    begin
                        head_new.en = 1'b0;
                    end
                end
            end
            default:
            begin
                head_new = head;
            end
        endcase
    end

    // final result of the request
    always_comb
    begin
        fin_status = 1'b0;
        fin_slot   = '0;
        fin_fired  = 1'b0;
        case (func_reg)
            mstb_pkg::FUNC_TICK:
            begin
                fin_status = 1'b0;
            end
            mstb_pkg::FUNC_CREATE:
            begin
                fin_status = !found_reg;
                fin_slot   = found_reg ? found_slot_reg : '0;
            end
            mstb_pkg::FUNC_DELETE:
            begin
                fin_status = !del_ok_reg;
                fin_slot   = sel_reg;
            end
            mstb_pkg::FUNC_POLL:
            begin
                fin_slot  = pend_valid_reg ? pend_slot_reg : '0;
                fin_fired = pend_valid_reg;
            end
            default:
            begin
                fin_status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mstb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            mstb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = mstb_pkg::ST_SWEEP;
                end
            end
            mstb_pkg::ST_SWEEP:
            begin
                if (advance && (cnt_reg == LAST_IDX))
                begin
                    state_next = mstb_pkg::ST_FLUSH;
                end
            end
            mstb_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = mstb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mstb_pkg::ST_IDLE;
            end
        endcase
    end

    // latch the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= mstb_pkg::func_t'(s_tuser);
            period_reg   <= s_tdata[15:0];
            periodic_reg <= s_tdata[16];
            notify_reg   <= s_tdata[17];
            sel_reg      <= s_tdata[20:18];
        end
    end

    // sweep bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            del_ok_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
        end
        else if (accept)
        begin
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            del_ok_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
            if (do_create)
            begin
                found_reg <= 1'b1;
            end
            if (do_delete)
            begin
                del_ok_reg <= 1'b1;
            end
            if (report)
            begin
                pend_valid_reg <= 1'b1;
                n_reg          <= n_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && do_create)
        begin
            found_slot_reg <= cnt_slot;
        end
        if (advance && report)
        begin
            pend_slot_reg <= cnt_slot;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_sweep || push_flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_sweep)
        begin
            out_status_reg <= 1'b0;
            out_slot_reg   <= pend_slot_reg;
            out_fired_reg  <= 1'b1;
            out_last_reg   <= 1'b0;
        end
        else if (push_flush)
        begin
            out_status_reg <= fin_status;
            out_slot_reg   <= fin_slot;
            out_fired_reg  <= fin_fired;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_fired_reg, out_slot_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    a_report_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= mstb_pkg::MAX_REPORTS)
        else $error("poll report count beyond limit");

    a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mstb_pkg::ST_FLUSH && out_free) |=> (m_tvalid && m_tlast))
        else $error("final result missing after flush");

    a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (sweeping && !advance) |-> (out_valid_reg && !m_tready && pend_valid_reg))
        else $error("ring stalled without a blocked result");

    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (sweeping && cnt_reg == '0 && !pend_valid_reg))
        else $error("sweep did not start from the first slot");

endmodule
